// ===== sv/ipv4fwd_pkg.sv =====
`default_nettype none

package ipv4fwd_pkg;

    // Frame layout
    localparam int MAX_IP_HEADER_BYTES = 60;
    localparam int MIN_IP_HEADER_BYTES = 20;
    localparam int MAC_BYTES           = 6;
    localparam int MAC_SPAN            = 12;
    localparam int ETH_HDR             = 14;
    localparam int TTL_OFF             = 8;
    localparam int CSUM_OFF            = 10;

    // Hold store: the MAC pair and the header tail share it
    localparam int HELD_DEPTH = (MAX_IP_HEADER_BYTES - CSUM_OFF > MAC_SPAN) ?
                                (MAX_IP_HEADER_BYTES - CSUM_OFF) : MAC_SPAN;
    localparam int HELD_AW    = $clog2(HELD_DEPTH);
    localparam int HELD_CW    = $clog2(HELD_DEPTH + 1);

    localparam int POS_W   = 7;
    localparam int POS_MAX = 127;
    localparam int HB_W    = $clog2(MAX_IP_HEADER_BYTES + 1);

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_MAC    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REWRITE_EN = 8'd1;

    // Back-end command kinds
    typedef logic [1:0] t_cmd_kind;
    localparam t_cmd_kind CMD_BYTE  = 2'd0;  // one byte from value[7:0]
    localparam t_cmd_kind CMD_MAC   = 2'd1;  // held source MAC, then own MAC
    localparam t_cmd_kind CMD_CSUM  = 2'd2;  // checksum, then held header tail
    localparam t_cmd_kind CMD_FLUSH = 2'd3;  // held bytes unchanged

    typedef struct packed {
        t_cmd_kind           kind;
        logic                last;
        logic [15:0]         value;
        logic [HELD_CW-1:0]  count;
    } t_cmd;

    typedef struct packed {
        logic                we;
        logic [HELD_AW-1:0]  addr;
        logic [7:0]          data;
    } t_hold_wr;

endpackage

`default_nettype wire

// ===== sv/ipv4fwd_ram.sv =====
`default_nettype none

module ipv4fwd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== sv/ipv4fwd_queue.sv =====
`default_nettype none

module ipv4fwd_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire ipv4fwd_pkg::t_cmd i_cmd,
    output logic                   o_full,
    output logic                   o_empty,
    output ipv4fwd_pkg::t_cmd      o_head,
    input  wire logic              i_pop
);
    import ipv4fwd_pkg::*;

    t_cmd                r_slot [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [QUEUE_CW-1:0] r_count, n_count;
    logic                w_push, w_pop;

    assign o_full  = (r_count == QUEUE_CW'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_slot[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = w_push ? r_wr_ptr + QUEUE_AW'(1) : r_wr_ptr;
        n_rd_ptr = w_pop  ? r_rd_ptr + QUEUE_AW'(1) : r_rd_ptr;
        n_count  = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + QUEUE_CW'(1);
        end else if (w_pop && !w_push) begin
            n_count = r_count - QUEUE_CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== sv/ipv4fwd_front.sv =====
`default_nettype none

module ipv4fwd_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    output logic                   o_full,
    input  wire logic [7:0]        i_frame_byte,
    input  wire logic              i_frame_end,
    input  wire logic              i_rewrite_en,
    input  wire logic              i_q_full,
    input  wire logic              i_q_empty,
    output logic                   o_q_push,
    output ipv4fwd_pkg::t_cmd      o_cmd,
    output ipv4fwd_pkg::t_hold_wr  o_hold_wr
);
    import ipv4fwd_pkg::*;

    logic [POS_W-1:0]   r_pos, n_pos;
    logic [HB_W-1:0]    r_hb, n_hb;
    logic [15:0]        r_sum, n_sum;
    logic [7:0]         r_pend, n_pend;
    logic [HELD_CW-1:0] r_cnt, n_cnt;
    logic               r_mode, n_mode;

    logic               w_mode, w_hold_phase, w_accept;
    logic [POS_W-1:0]   w_off;
    logic [7:0]         w_hl8;
    logic [HB_W-1:0]    w_hl, w_hb;
    logic [7:0]         w_v;
    logic [16:0]        w_sum_raw;
    logic [15:0]        w_sum_add;
    logic [HELD_CW-1:0] w_cnt_inc;

    // The mode is latched on the first byte of a frame
    assign w_mode = (r_pos == '0) ? i_rewrite_en : r_mode;
    assign w_off  = r_pos - POS_W'(ETH_HDR);

    // Hold writes wait until the back end has no reader left on the store
    assign w_hold_phase = w_mode && ((r_pos < POS_W'(MAC_SPAN)) ||
                          ((r_pos >= POS_W'(ETH_HDR + CSUM_OFF)) && (w_off < POS_W'(r_hb))));
    assign o_full   = i_q_full || (w_hold_phase && !i_q_empty);
    assign w_accept = i_push && !o_full;

    always_comb begin
        w_hl8 = {2'b00, i_frame_byte[3:0], 2'b00};
        if (w_hl8 < 8'(MIN_IP_HEADER_BYTES)) begin
            w_hl8 = 8'(MIN_IP_HEADER_BYTES);
        end else if (w_hl8 > 8'(MAX_IP_HEADER_BYTES)) begin
            w_hl8 = 8'(MAX_IP_HEADER_BYTES);
        end
    end

    assign w_hl      = HB_W'(w_hl8);
    assign w_hb      = (w_off == '0) ? w_hl : r_hb;
    assign w_v       = (w_off == POS_W'(TTL_OFF)) ? i_frame_byte - 8'd1 : i_frame_byte;
    assign w_sum_raw = {1'b0, r_sum} + {1'b0, r_pend, w_v};
    assign w_sum_add = w_sum_raw[16] ? w_sum_raw[15:0] + 16'd1 : w_sum_raw[15:0];
    assign w_cnt_inc = r_cnt + HELD_CW'(1);

    always_comb begin
        n_pos          = r_pos;
        n_hb           = r_hb;
        n_sum          = r_sum;
        n_pend         = r_pend;
        n_cnt          = r_cnt;
        n_mode         = r_mode;
        o_q_push       = 1'b0;
        o_cmd.kind     = CMD_BYTE;
        o_cmd.last     = i_frame_end;
        o_cmd.value    = {8'h00, i_frame_byte};
        o_cmd.count    = w_cnt_inc;
        o_hold_wr.we   = 1'b0;
        o_hold_wr.addr = r_cnt[HELD_AW-1:0];
        o_hold_wr.data = w_v;

        if (w_accept) begin
            n_pos = (r_pos == POS_W'(POS_MAX)) ? r_pos : r_pos + POS_W'(1);
            if (r_pos == '0) begin
                n_mode = i_rewrite_en;
            end

            if (!w_mode) begin
                o_q_push = 1'b1;
            end else if (r_pos < POS_W'(MAC_SPAN)) begin
                o_hold_wr.we = 1'b1;
                if (r_pos == POS_W'(MAC_SPAN - 1)) begin
                    o_q_push   = 1'b1;
                    o_cmd.kind = CMD_MAC;
                    n_cnt      = '0;
                end else begin
                    n_cnt = w_cnt_inc;
                    if (i_frame_end) begin
                        o_q_push   = 1'b1;
                        o_cmd.kind = CMD_FLUSH;
                    end
                end
            end else if (r_pos < POS_W'(ETH_HDR)) begin
                o_q_push = 1'b1;
            end else begin
                if (w_off == '0) begin
                    n_hb = w_hl;
                end
                if (w_off < POS_W'(w_hb)) begin
                    // Checksum word itself is summed as zero
                    if ((w_off != POS_W'(CSUM_OFF)) && (w_off != POS_W'(CSUM_OFF + 1))) begin
                        if (!w_off[0]) begin
                            n_pend = w_v;
                        end else begin
                            n_sum = w_sum_add;
                        end
                    end
                    if (w_off < POS_W'(CSUM_OFF)) begin
                        o_q_push    = 1'b1;
                        o_cmd.value = {8'h00, w_v};
                    end else begin
                        o_hold_wr.we = 1'b1;
                        if (w_off == POS_W'(w_hb) - POS_W'(1)) begin
                            o_q_push    = 1'b1;
                            o_cmd.kind  = CMD_CSUM;
                            o_cmd.value = ~w_sum_add;
                            n_cnt       = '0;
                        end else begin
                            n_cnt = w_cnt_inc;
                            if (i_frame_end) begin
                                o_q_push   = 1'b1;
                                o_cmd.kind = CMD_FLUSH;
                            end
                        end
                    end
                end else begin
                    o_q_push = 1'b1;
                end
            end

            if (i_frame_end) begin
                n_pos  = '0;
                n_hb   = HB_W'(MIN_IP_HEADER_BYTES);
                n_sum  = '0;
                n_pend = '0;
                n_cnt  = '0;
                n_mode = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_hb   <= HB_W'(MIN_IP_HEADER_BYTES);
            r_sum  <= '0;
            r_pend <= '0;
            r_cnt  <= '0;
            r_mode <= 1'b0;
        end else begin
            r_pos  <= n_pos;
            r_hb   <= n_hb;
            r_sum  <= n_sum;
            r_pend <= n_pend;
            r_cnt  <= n_cnt;
            r_mode <= n_mode;
        end
    end

endmodule

`default_nettype wire

// ===== sv/ipv4fwd_back.sv =====
`default_nettype none

module ipv4fwd_back (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire ipv4fwd_pkg::t_cmd                  i_head,
    input  wire logic                               i_q_empty,
    output logic                                    o_q_pop,
    input  wire logic [47:0]                        i_own_mac,
    output logic                                    o_ram_re,
    output logic [ipv4fwd_pkg::HELD_AW-1:0]         o_ram_raddr,
    input  wire logic [7:0]                         i_ram_rdata,
    output logic                                    o_empty,
    input  wire logic                               i_pop,
    output logic [7:0]                              o_out_byte,
    output logic                                    o_out_end
);
    import ipv4fwd_pkg::*;

    logic [HELD_CW-1:0] r_idx;
    logic               r_b_valid, r_b_ram, r_b_end;
    logic [7:0]         r_b_byte;
    logic               r_out_valid, r_out_end;
    logic [7:0]         r_out_byte;

    logic               w_adv_out, w_adv_b, w_issue;
    logic               w_el_last, w_el_ram;
    logic [7:0]         w_el_byte, w_mac_byte;
    logic [HELD_AW-1:0] w_el_addr;
    logic [2:0]         w_mac_k;
    logic               w_cnt_last;

    assign w_adv_out  = !r_out_valid || i_pop;
    assign w_adv_b    = !r_b_valid || w_adv_out;
    assign w_issue    = !i_q_empty && w_adv_b;
    assign w_cnt_last = (r_idx == i_head.count - HELD_CW'(1));
    assign w_mac_k    = 3'(r_idx - HELD_CW'(MAC_BYTES));

    always_comb begin
        case (w_mac_k)
            3'd0:    w_mac_byte = i_own_mac[47:40];
            3'd1:    w_mac_byte = i_own_mac[39:32];
            3'd2:    w_mac_byte = i_own_mac[31:24];
            3'd3:    w_mac_byte = i_own_mac[23:16];
            3'd4:    w_mac_byte = i_own_mac[15:8];
            default: w_mac_byte = i_own_mac[7:0];
        endcase
    end

    // Expand the head command into one byte per step
    always_comb begin
        w_el_ram  = 1'b0;
        w_el_byte = i_head.value[7:0];
        w_el_addr = r_idx[HELD_AW-1:0];
        w_el_last = 1'b1;
        unique case (i_head.kind)
            CMD_BYTE: begin
                w_el_last = 1'b1;
            end
            CMD_MAC: begin
                w_el_last = (r_idx == HELD_CW'(MAC_SPAN - 1));
                if (r_idx < HELD_CW'(MAC_BYTES)) begin
                    w_el_ram  = 1'b1;
                    w_el_addr = HELD_AW'(r_idx + HELD_CW'(MAC_BYTES));
                end else begin
                    w_el_byte = w_mac_byte;
                end
            end
            CMD_CSUM: begin
                w_el_last = w_cnt_last;
                if (r_idx == '0) begin
                    w_el_byte = i_head.value[15:8];
                end else if (r_idx == HELD_CW'(1)) begin
                    w_el_byte = i_head.value[7:0];
                end else begin
                    w_el_ram = 1'b1;
                end
            end
            CMD_FLUSH: begin
                w_el_last = w_cnt_last;
                w_el_ram  = 1'b1;
            end
            default: begin
                w_el_last = 1'b1;
            end
        endcase
    end

    assign o_q_pop     = w_issue && w_el_last;
    assign o_ram_re    = w_issue && w_el_ram;
    assign o_ram_raddr = w_el_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_b_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_issue) begin
                r_idx <= w_el_last ? '0 : r_idx + HELD_CW'(1);
            end
            if (w_adv_b) begin
                r_b_valid <= w_issue;
            end
            if (w_adv_out) begin
                r_out_valid <= r_b_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv_b) begin
            r_b_ram  <= w_el_ram;
            r_b_byte <= w_el_byte;
            r_b_end  <= w_el_last && i_head.last;
        end
        if (w_adv_out) begin
            r_out_byte <= r_b_ram ? i_ram_rdata : r_b_byte;
            r_out_end  <= r_b_end;
        end
    end

    assign o_empty    = !r_out_valid;
    assign o_out_byte = r_out_byte;
    assign o_out_end  = r_out_end;

endmodule

`default_nettype wire

// ===== sv/ipv4_frame_forward_rewriter.sv =====
// IPv4 forwarding rewriter: one frame byte per item in, one byte per item out.
// Input channel: push/full; a byte is taken on an edge with push high and full
// low. Result channel: empty/pop; the oldest byte sits on o_out_byte/o_out_end
// while empty is low and leaves on an edge with pop high.
// Configuration: i_cfg_valid/o_cfg_ready (ready is always high), i_cfg_index
// selects own_mac (0) or rewrite_enable (1); other indexes are ignored.
// A pass-through byte is held in the command queue, r_b and r_out in turn.
// Pass-through frames move one byte per cycle on both sides while pop is high.
// Destination/source MAC bytes are collected over 12 items and then leave as a
// burst of 12; IP header bytes from the checksum field on are collected until
// the header ends and then leave as a burst of up to 50. While such a group is
// being collected, full stays high whenever a command still waits in the
// queue; full also rises when the 4-entry command queue fills, so a rewritten
// frame takes extra input cycles while these bursts drain.
// A stalled receiver holds the output byte; the queue absorbs a few commands
// and then full holds the sender. Reset empties the pipeline, clears the frame
// state and both configuration registers; the hold store needs no clearing.
`default_nettype none

module ipv4_frame_forward_rewriter (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              push,
    output logic                                   full,
    input  wire logic [7:0]                        i_frame_byte,
    input  wire logic                              i_frame_end,
    output logic                                   empty,
    input  wire logic                              pop,
    output logic [7:0]                             o_out_byte,
    output logic                                   o_out_end,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [ipv4fwd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [47:0]                       i_cfg_data
);
    import ipv4fwd_pkg::*;

    // Configuration registers
    logic [47:0]        r_own_mac;
    logic               r_rewrite_en;

    // Front end to queue and hold store, queue to back end
    logic               w_q_push, w_q_full, w_q_empty, w_q_pop;
    t_cmd               w_cmd, w_head;
    t_hold_wr           w_hold_wr;

    // Back end to hold store
    logic               w_ram_re;
    logic [HELD_AW-1:0] w_ram_raddr;
    logic [7:0]         w_ram_rdata;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_mac    <= '0;
            r_rewrite_en <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_OWN_MAC) begin
                r_own_mac <= i_cfg_data;
            end else if (i_cfg_index == CFG_REWRITE_EN) begin
                r_rewrite_en <= i_cfg_data[0];
            end
        end
    end

    // Classify each byte, collect held bytes, issue output commands
    ipv4fwd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_frame_byte (i_frame_byte),
        .i_frame_end  (i_frame_end),
        .i_rewrite_en (r_rewrite_en),
        .i_q_full     (w_q_full),
        .i_q_empty    (w_q_empty),
        .o_q_push     (w_q_push),
        .o_cmd        (w_cmd),
        .o_hold_wr    (w_hold_wr)
    );

    // Decouple the two halves
    ipv4fwd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_cmd   (w_cmd),
        .o_full  (w_q_full),
        .o_empty (w_q_empty),
        .o_head  (w_head),
        .i_pop   (w_q_pop)
    );

    // Held MAC and header bytes
    ipv4fwd_ram #(
        .WIDTH (8),
        .DEPTH (HELD_DEPTH)
    ) u_hold (
        .i_clk   (i_clk),
        .i_we    (w_hold_wr.we),
        .i_waddr (w_hold_wr.addr),
        .i_wdata (w_hold_wr.data),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    // Expand commands into output bytes
    ipv4fwd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .i_q_empty   (w_q_empty),
        .o_q_pop     (w_q_pop),
        .i_own_mac   (r_own_mac),
        .o_ram_re    (w_ram_re),
        .o_ram_raddr (w_ram_raddr),
        .i_ram_rdata (w_ram_rdata),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_out_byte  (o_out_byte),
        .o_out_end   (o_out_end)
    );

endmodule

`default_nettype wire

// ===== sv/ipv4fwd_checker.sv =====
`default_nettype none

module ipv4fwd_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        full,
    input wire logic        empty,
    input wire logic        pop,
    input wire logic [7:0]  o_out_byte,
    input wire logic        o_out_end,
    input wire logic        o_cfg_ready
);

    // Reset leaves no result behind and the input open
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("empty/full wrong after reset");

    // A waiting result holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_out_byte) && $stable(o_out_end)))
        else $error("stalled result changed");

    // Configuration writes are never refused
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("configuration port not ready");

    // A waiting result never carries unknown bits
    a_out_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> !$isunknown({o_out_byte, o_out_end}))
        else $error("unknown bits on a waiting result");

endmodule

bind ipv4_frame_forward_rewriter ipv4fwd_checker u_checker (.*);

`default_nettype wire
